@@ src/lape_pkg.sv @@
// Shared types, codes and constants of the LED animation pattern engine.
package lape_pkg;

  // Width of the wrapping millisecond time used for all elapsed-time checks
  localparam int TIME_BITS = 32;
  localparam int NOW_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int WORD_W    = 8;
  localparam int NUM_MODES = 7;
  localparam int NUM_SEGS  = 7;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [WORD_W-1:0]    word_t;

  // Animation modes carried by each poll
  typedef enum logic [2:0] {
    FUNC_NONE    = 3'd0,
    FUNC_FILL    = 3'd1,
    FUNC_BLINK   = 3'd2,
    FUNC_RANDOM  = 3'd3,
    FUNC_BREATHE = 3'd4,
    FUNC_WAVE    = 3'd5,
    FUNC_CHASE   = 3'd6,
    FUNC_FLASH   = 3'd7
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQUENCE  = 3'd0,
    CFG_BLINK     = 3'd1,
    CFG_RANDOM    = 3'd2,
    CFG_BREATHING = 3'd3,
    CFG_WAVE      = 3'd4,
    CFG_CHASE     = 3'd5,
    CFG_FLASH     = 3'd6,
    CFG_SHELL     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] sequence_interval;
    logic [CFG_W-1:0] blink_interval;
    logic [CFG_W-1:0] random_interval;
    logic [CFG_W-1:0] breathing_interval;
    logic [CFG_W-1:0] wave_interval;
    logic [CFG_W-1:0] chase_interval;
    logic [CFG_W-1:0] flash_interval;
    logic [CFG_W-1:0] shell_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sequence_interval:  16'd600,
    blink_interval:     16'd300,
    random_interval:    16'd400,
    breathing_interval: 16'd50,
    wave_interval:      16'd150,
    chase_interval:     16'd200,
    flash_interval:     16'd150,
    shell_period:       16'd2000
  };

  // Drive word constants
  localparam word_t WORD_ALL       = 8'hFF;
  localparam word_t WORD_SHELL     = 8'h80;
  localparam word_t WORD_SEGS      = 8'h7F;
  localparam word_t WORD_FLASH_OFF = 8'hEF;
  localparam word_t WORD_OFF       = 8'h00;

  localparam logic [4:0]  BREATH_PHASES = 5'd28;
  localparam logic [4:0]  BREATH_HALF   = 5'd14;
  localparam logic [15:0] LFSR_SEED     = 16'hACE1;

endpackage

@@ src/lape_in_if.sv @@
// Poll channel: millisecond time and animation mode.
interface lape_in_if import lape_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NOW_W-1:0] now_ms;
  func_t            func;

  modport source (output valid, output now_ms, output func, input ready);
  modport sink   (input valid, input now_ms, input func, output ready);
endinterface

@@ src/lape_out_if.sv @@
// Result channel: LED drive word.
interface lape_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] led_drive;

  modport source (output valid, output led_drive, input ready);
  modport sink   (input valid, input led_drive, output ready);
endinterface

@@ src/led_animation_pattern_engine.sv @@
// Top level of the LED animation pattern engine: poll register, engine, result register.
// One poll item is taken every clock cycle while the result side keeps up; a result
// passes the poll register, then the result register, after its poll is accepted.
// The rate is set by the compute stage between those registers, which reads and updates
// all pattern state as each poll fires, so each poll sees the state left by the one
// before. A stall on the result side holds one result and one waiting poll; input
// ready drops only when both are full. Configuration writes take effect next cycle.
module led_animation_pattern_engine import lape_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lape_in_if.sink              in_if,
  lape_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t             cfg;
  logic             in_valid_r;
  logic [NOW_W-1:0] in_now_r;
  func_t            in_func_r;
  logic             out_valid_r;
  word_t            out_drive_r;
  word_t            led_nxt;
  logic             advance;
  logic             fire;
  logic             in_ready;

  lape_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lape_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .now     (time_t'(in_now_r)),
    .func    (in_func_r),
    .cfg     (cfg),
    .led_nxt (led_nxt)
  );

  // Stage flow control
  assign advance  = !out_valid_r || out_if.ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || fire;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_if.valid;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_ready) begin
      in_now_r  <= in_if.now_ms;
      in_func_r <= in_if.func;
    end
    if (fire) out_drive_r <= led_nxt;
  end

  assign in_if.ready      = in_ready;
  assign out_if.valid     = out_valid_r;
  assign out_if.led_drive = out_drive_r;

  // Pipeline bookkeeping
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("computed item did not reach result register");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !fire)
    else $error("result overwritten while stalled");
  a_poll_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !fire) |=> in_valid_r && $stable(in_func_r) && $stable(in_now_r))
    else $error("waiting poll lost or changed");

endmodule

@@ src/lape_cfg.sv @@
// Configuration register file: mode intervals and shell period.
module lape_cfg import lape_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // Write by index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SEQUENCE:  cfg_r.sequence_interval  <= cfg_wdata;
        CFG_BLINK:     cfg_r.blink_interval     <= cfg_wdata;
        CFG_RANDOM:    cfg_r.random_interval    <= cfg_wdata;
        CFG_BREATHING: cfg_r.breathing_interval <= cfg_wdata;
        CFG_WAVE:      cfg_r.wave_interval      <= cfg_wdata;
        CFG_CHASE:     cfg_r.chase_interval     <= cfg_wdata;
        CFG_FLASH:     cfg_r.flash_interval     <= cfg_wdata;
        CFG_SHELL:     cfg_r.shell_period       <= cfg_wdata;
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/lape_engine.sv @@
// Per-mode timers and pattern state; computes the next drive word for one poll.
module lape_engine import lape_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  time_t now,
  input  func_t func,
  input  cfg_t  cfg,
  output word_t led_nxt
);

  // Pattern state
  time_t      mode_last_r [NUM_MODES];
  time_t      hold_start_r, hold_start_nxt;
  time_t      toggle_start_r, toggle_start_nxt;
  logic       shell_lit_r, shell_lit_nxt;
  logic [2:0] fill_idx_r, fill_idx_nxt;
  logic       blink_r, blink_nxt;
  logic [4:0] breath_r, breath_nxt;
  logic [2:0] wave_pos_r, wave_pos_nxt;
  logic [2:0] chase_pos_r, chase_pos_nxt;
  logic       chase_back_r, chase_back_nxt;
  logic       flash_r, flash_nxt;
  logic [15:0] lfsr_r, lfsr_nxt;
  word_t      word_r, word_nxt;

  // Timer check signals
  logic             active;
  logic [2:0]       mode_idx;
  logic [CFG_W-1:0] interval;
  time_t            last_time;
  time_t            elapsed;
  logic             due;
  time_t            hold_elapsed;
  time_t            toggle_elapsed;

  // Pattern helpers
  logic       lfsr_bit;
  logic [4:0] breath_step;
  logic [2:0] breath_cnt;
  logic [3:0] wave_sum;
  word_t      wave_mask;
  logic [2:0] chase_seg;

  // Mode timer: select this mode's interval and timestamp
  always_comb begin
    active   = (func != FUNC_NONE);
    mode_idx = 3'(func) - 3'd1;
    case (func)
      FUNC_FILL:    interval = cfg.sequence_interval;
      FUNC_BLINK:   interval = cfg.blink_interval;
      FUNC_RANDOM:  interval = cfg.random_interval;
      FUNC_BREATHE: interval = cfg.breathing_interval;
      FUNC_WAVE:    interval = cfg.wave_interval;
      FUNC_CHASE:   interval = cfg.chase_interval;
      FUNC_FLASH:   interval = cfg.flash_interval;
      default:      interval = '0;
    endcase
    last_time = active ? mode_last_r[mode_idx] : '0;
    elapsed   = now - last_time;
    due       = active && (elapsed >= time_t'(interval));
    // fill hold restarts at this poll when the full word is lit now
    hold_elapsed   = (due && fill_idx_r == 3'd7) ? '0 : (now - hold_start_r);
    toggle_elapsed = now - toggle_start_r;
  end

  // Small pattern helpers
  always_comb begin
    lfsr_bit    = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];
    breath_step = (breath_r + 5'd1 >= BREATH_PHASES) ? 5'd0 : breath_r + 5'd1;
    if (breath_step < BREATH_HALF) begin
      breath_cnt = breath_step[3:1];
    end else begin
      breath_cnt = 3'd7 - 3'((breath_step - BREATH_HALF) >> 1);
    end
    wave_mask = WORD_OFF;
    wave_sum  = '0;
    for (int i = 0; i < 3; i++) begin
      wave_sum = {1'b0, wave_pos_r} + 4'(i);
      if (wave_sum >= 4'(NUM_SEGS)) wave_sum = wave_sum - 4'(NUM_SEGS);
      wave_mask = wave_mask | (word_t'(1) << wave_sum[2:0]);
    end
    chase_seg = (chase_pos_r == 3'd7) ? 3'd0 : chase_pos_r;
  end

  // Next state for one poll
  always_comb begin
    hold_start_nxt   = hold_start_r;
    toggle_start_nxt = toggle_start_r;
    shell_lit_nxt    = shell_lit_r;
    fill_idx_nxt     = fill_idx_r;
    blink_nxt        = blink_r;
    breath_nxt       = breath_r;
    wave_pos_nxt     = wave_pos_r;
    chase_pos_nxt    = chase_pos_r;
    chase_back_nxt   = chase_back_r;
    flash_nxt        = flash_r;
    lfsr_nxt         = lfsr_r;
    word_nxt         = word_r;
    if (fire) begin
      case (func)
        FUNC_FILL: begin
          if (due) begin
            if (fill_idx_r != 3'd7) begin
              word_nxt = word_t'(1) << fill_idx_r;
            end else begin
              word_nxt       = WORD_ALL;
              hold_start_nxt = now;
            end
            fill_idx_nxt = fill_idx_r + 3'd1;
          end
          if (word_nxt == WORD_ALL && hold_elapsed >= time_t'(cfg.shell_period)) begin
            word_nxt = WORD_OFF;
          end
        end
        FUNC_BLINK: begin
          if (due) begin
            blink_nxt = !blink_r;
            word_nxt  = blink_r ? WORD_SHELL : WORD_ALL;
          end
        end
        FUNC_RANDOM: begin
          if (due) begin
            lfsr_nxt = {lfsr_bit, lfsr_r[15:1]};
            word_nxt = (lfsr_nxt[7:0] & WORD_SEGS) | WORD_SHELL;
          end
        end
        FUNC_BREATHE: begin
          if (due) begin
            breath_nxt = breath_step;
            word_nxt   = (((word_t'(1) << breath_cnt) - word_t'(1)) & WORD_SEGS) | WORD_SHELL;
          end
        end
        FUNC_WAVE: begin
          if (due) begin
            word_nxt     = wave_mask;
            wave_pos_nxt = (wave_pos_r >= 3'(NUM_SEGS - 1)) ? 3'd0 : wave_pos_r + 3'd1;
          end
          if (toggle_elapsed >= time_t'(cfg.shell_period)) begin
            toggle_start_nxt = now;
            shell_lit_nxt    = !shell_lit_r;
          end
          if (shell_lit_nxt) word_nxt = word_nxt | WORD_SHELL;
        end
        FUNC_CHASE: begin
          if (due) begin
            word_nxt = (word_t'(1) << chase_seg) | WORD_SHELL;
            if (!chase_back_r) begin
              if (chase_pos_r >= 3'(NUM_SEGS - 1)) begin
                chase_pos_nxt  = 3'(NUM_SEGS - 1);
                chase_back_nxt = 1'b1;
              end else begin
                chase_pos_nxt = chase_pos_r + 3'd1;
              end
            end else if (chase_pos_r == 3'd0) begin
              chase_back_nxt = 1'b0;
              chase_pos_nxt  = 3'd1;
            end else begin
              chase_pos_nxt = chase_pos_r - 3'd1;
            end
          end
        end
        FUNC_FLASH: begin
          if (due) begin
            flash_nxt = !flash_r;
            word_nxt  = flash_r ? WORD_FLASH_OFF : WORD_ALL;
          end
        end
        default: word_nxt = word_r;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MODES; i++) mode_last_r[i] <= '0;
      hold_start_r   <= '0;
      toggle_start_r <= '0;
      shell_lit_r    <= 1'b1;
      fill_idx_r     <= '0;
      blink_r        <= 1'b0;
      breath_r       <= '0;
      wave_pos_r     <= '0;
      chase_pos_r    <= '0;
      chase_back_r   <= 1'b0;
      flash_r        <= 1'b0;
      lfsr_r         <= LFSR_SEED;
      word_r         <= WORD_OFF;
    end else begin
      if (fire && due) mode_last_r[mode_idx] <= now;
      hold_start_r   <= hold_start_nxt;
      toggle_start_r <= toggle_start_nxt;
      shell_lit_r    <= shell_lit_nxt;
      fill_idx_r     <= fill_idx_nxt;
      blink_r        <= blink_nxt;
      breath_r       <= breath_nxt;
      wave_pos_r     <= wave_pos_nxt;
      chase_pos_r    <= chase_pos_nxt;
      chase_back_r   <= chase_back_nxt;
      flash_r        <= flash_nxt;
      lfsr_r         <= lfsr_nxt;
      word_r         <= word_nxt;
    end
  end

  assign led_nxt = word_nxt;

  // Counter ranges and LFSR lock-up
  a_breath_range: assert property (@(posedge clk) disable iff (!rst_n)
    breath_r < BREATH_PHASES)
    else $error("breath phase out of range");
  a_wave_range: assert property (@(posedge clk) disable iff (!rst_n)
    wave_pos_r != 3'(NUM_SEGS))
    else $error("wave position out of range");
  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("LFSR locked at zero");

endmodule
